// ----- rtl/glatm_pkg.sv -----
// Shared types, constants and constant tables for the global log-average tone mapper.
// No dependencies; every other file of the block imports this package.
package glatm_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_STAT  = 2'd1;
    localparam logic [1:0] MODE_MAP   = 2'd2;

    localparam logic CFG_KEY   = 1'b0;
    localparam logic CFG_WHITE = 1'b1;

    localparam logic [31:0] KEY_RESET   = 32'd11796;
    localparam logic [31:0] WHITE_RESET = 32'd65536;

    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46871;
    localparam logic [15:0] COEF_B = 16'd4732;

    localparam logic [24:0] MAX_PIX = 25'd16777216;
    localparam logic [47:0] SAT48   = 48'hFFFF_FFFF_FFFF;
    // negated log2 of epsilon in Q8.16
    localparam logic signed [49:0] EPS_T = 50'sd1306235;

    typedef enum logic [1:0] {
        KIND_START,
        KIND_STAT,
        KIND_MAP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] blue;
        logic [31:0] green;
        logic [31:0] red;
    } item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] white;
    } cfg_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [48:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [48:0] rem;
    } div_rsp_t;

    typedef logic [31:0] root_tab_t [16];

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        int          i;
        res  = '0;
        bitv = 64'h4000_0000_0000_0000;
        rem  = v;
        for (i = 0; i < 32; i++) begin
            if (bitv > rem) bitv = bitv >> 2;
        end
        for (i = 0; i < 32; i++) begin
            if (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
        end
        return res;
    endfunction

    // successive square roots of 2.0 in Q2.30
    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] c;
        int          k;
        c = 64'h8000_0000;
        for (k = 0; k < 16; k++) begin
            c      = isqrt64(c << 30);
            tab[k] = c[31:0];
        end
        return tab;
    endfunction

    localparam root_tab_t ROOT_TAB = build_roots();

endpackage

// ----- rtl/glatm_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on glatm_pkg for the request and response structs.
module glatm_div import glatm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] num_reg;
    logic [48:0] rem_reg;
    logic [48:0] den_reg;
    logic [49:0] trial;
    logic        ge;

    assign trial = {rem_reg, num_reg[63]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            num_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                num_reg  <= req.num;
                rem_reg  <= '0;
                den_reg  <= req.den;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? 49'(trial - {1'b0, den_reg}) : trial[48:0];
                num_reg <= {num_reg[62:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = num_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- rtl/glatm_front.sv -----
// Input side: accepts stream requests, classifies the mode and queues work items.
// Depends on glatm_pkg for item_t and the mode codes.
module glatm_front import glatm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // blue, green, red
    input  logic [1:0]  s_tuser,   // mode
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      fifo_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       keep;
    kind_t      kind;
    logic       push;

    always_comb
    begin
        keep = 1'b1;
        kind = KIND_MAP;
        case (s_tuser)
            MODE_START: kind = KIND_START;
            MODE_STAT:  kind = KIND_STAT;
            MODE_MAP:   kind = KIND_MAP;
            default:    keep = 1'b0;
        endcase
    end

    assign s_tready = count_reg != 2'd2;
    assign push     = s_tvalid && s_tready && keep;
    assign q_valid  = count_reg != 2'd0;
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                fifo_reg[wr_ptr_reg] <= '{kind, s_tdata[31:0], s_tdata[63:32], s_tdata[95:64]};
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end

endmodule

// ----- rtl/glatm_back.sv -----
// Execution side: luminance, log2 statistics, scale forming and per-channel mapping
// on one shared multiplier and the shared divider. Depends on glatm_pkg.
module glatm_back import glatm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    input  cfg_t        cfg,
    output div_req_t    div_req,
    input  div_rsp_t    div_rsp,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LUM, ST_LUMF, ST_NORM, ST_SQ, ST_ACCUM,
        ST_MEAN, ST_MEANW, ST_POW, ST_KEYM, ST_SCL,
        ST_MSL, ST_MSH, ST_SSAT, ST_DIVA, ST_DIVAW, ST_DIVU, ST_DIVUW,
        ST_DIVV, ST_DIVVW, ST_CA, ST_PP, ST_XS, ST_KS, ST_OUT
    } state_t;

    state_t             state_reg;
    item_t              item_reg;
    logic [3:0]         cnt_reg;
    logic [48:0]        lacc_reg;
    logic [31:0]        lum_reg;
    logic [31:0]        m_reg;
    logic [4:0]         p_reg;
    logic [15:0]        frac_reg;
    logic signed [47:0] log_sum_reg;
    logic [24:0]        count_reg;
    logic [47:0]        scale_reg;
    logic               scale_ready_reg;
    logic signed [49:0] t_reg;
    logic [31:0]        acc_reg;
    logic [63:0]        prod_reg;
    logic [79:0]        wide_reg;
    logic [47:0]        s_reg;
    logic [24:0]        a_reg;
    logic [47:0]        u_reg;
    logic [47:0]        bq_reg;
    logic [1:0]         ch_reg;
    logic [56:0]        p1_reg;
    logic [104:0]       pacc_reg;
    logic [112:0]       x_reg;
    logic [7:0]         k_reg;
    logic [7:0]         och_reg [3];
    logic               out_valid_reg;
    logic [23:0]        out_data_reg;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [31:0]        lum_w;
    logic [31:0]        chan;
    logic [31:0]        c_eff;
    logic [31:0]        l_eff;
    logic [31:0]        w_eff;
    logic               neg;
    logic [47:0]        mag;
    logic signed [35:0] e_w;
    logic [35:0]        ne_w;
    logic [47:0]        scale_w;
    logic [63:0]        shr_w;
    logic [63:0]        s64;
    logic [7:0]         try_k;
    logic               fits;
    logic [7:0]         k_new;
    logic [20:0]        log_val;
    logic [104:0]       pp_add;

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign lum_w   = 32'((lacc_reg + 49'd32768) >> 16);
    assign c_eff   = (lum_reg == 32'd0) ? 32'd1 : chan;
    assign l_eff   = (lum_reg == 32'd0) ? 32'd1 : lum_reg;
    assign w_eff   = (cfg.white == 32'd0) ? 32'd1 : cfg.white;
    assign neg     = log_sum_reg[47];
    assign mag     = neg ? 48'(-log_sum_reg) : 48'(log_sum_reg);
    assign log_val = {p_reg - 5'd16, frac_reg};
    assign s64     = wide_reg[79:16];
    assign try_k   = k_reg | (8'h80 >> cnt_reg[2:0]);
    assign fits    = {33'd0, mul_p[39:0], 40'd0} <= x_reg;
    assign k_new   = fits ? try_k : k_reg;
    assign mul_p   = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        case (ch_reg)
            2'd0:    chan = item_reg.blue;
            2'd1:    chan = item_reg.green;
            default: chan = item_reg.red;
        endcase
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_LUM:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = item_reg.red;   mul_b = {16'd0, COEF_R}; end
                    2'd1:    begin mul_a = item_reg.green; mul_b = {16'd0, COEF_G}; end
                    default: begin mul_a = item_reg.blue;  mul_b = {16'd0, COEF_B}; end
                endcase
            end
            ST_SQ:   begin mul_a = m_reg;   mul_b = m_reg; end
            ST_POW:  begin mul_a = acc_reg; mul_b = ROOT_TAB[cnt_reg]; end
            ST_KEYM: begin mul_a = cfg.key; mul_b = acc_reg; end
            ST_MSL:  begin mul_a = {8'd0, scale_reg[23:0]};  mul_b = lum_reg; end
            ST_MSH:  begin mul_a = {8'd0, scale_reg[47:24]}; mul_b = lum_reg; end
            ST_CA:   begin mul_a = c_eff;   mul_b = {7'd0, a_reg}; end
            ST_PP:
            begin
                case (cnt_reg[1:0])
                    2'd0:    begin mul_a = {3'd0, p1_reg[28:0]};  mul_b = {8'd0, bq_reg[23:0]};  end
                    2'd1:    begin mul_a = {3'd0, p1_reg[28:0]};  mul_b = {8'd0, bq_reg[47:24]}; end
                    2'd2:    begin mul_a = {4'd0, p1_reg[56:29]}; mul_b = {8'd0, bq_reg[23:0]};  end
                    default: begin mul_a = {4'd0, p1_reg[56:29]}; mul_b = {8'd0, bq_reg[47:24]}; end
                endcase
            end
            ST_KS:   begin mul_a = l_eff;   mul_b = {24'd0, try_k}; end
            default: ;
        endcase
    end

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    pp_add = 105'(mul_p);
            2'd1:    pp_add = 105'(mul_p) << 24;
            2'd2:    pp_add = 105'(mul_p) << 29;
            default: pp_add = 105'(mul_p) << 53;
        endcase
    end

    // key times 2^-mean, shifted by the integer part of the exponent
    always_comb
    begin
        e_w     = 36'($signed(t_reg[49:16])) - 36'sd30;
        ne_w    = 36'(-e_w);
        shr_w   = '0;
        scale_w = '0;
        if (!e_w[35])
        begin
            if (prod_reg == 64'd0)
                scale_w = '0;
            else if (e_w >= 36'sd48)
                scale_w = SAT48;
            else if (prod_reg > (64'(SAT48) >> e_w[5:0]))
                scale_w = SAT48;
            else
                scale_w = 48'(prod_reg << e_w[5:0]);
        end
        else
        begin
            if (ne_w < 36'd64) shr_w = prod_reg >> ne_w[5:0];
            scale_w = (shr_w > 64'(SAT48)) ? SAT48 : shr_w[47:0];
        end
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (state_reg)
            ST_MEAN:
            begin
                div_req.start = count_reg != 25'd0;
                div_req.num   = 64'(mag);
                div_req.den   = 49'(count_reg);
            end
            ST_DIVA:
            begin
                div_req.start = 1'b1;
                div_req.num   = 64'h100_0000_0000;
                div_req.den   = 49'(s_reg) + 49'd65536;
            end
            ST_DIVU:
            begin
                div_req.start = 1'b1;
                div_req.num   = {s_reg, 16'd0};
                div_req.den   = 49'(w_eff);
            end
            ST_DIVV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {u_reg, 16'd0};
                div_req.den   = 49'(w_eff);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            item_reg        <= '0;
            cnt_reg         <= '0;
            lacc_reg        <= '0;
            lum_reg         <= '0;
            m_reg           <= '0;
            p_reg           <= '0;
            frac_reg        <= '0;
            log_sum_reg     <= '0;
            count_reg       <= '0;
            scale_reg       <= '0;
            scale_ready_reg <= 1'b0;
            t_reg           <= '0;
            acc_reg         <= '0;
            prod_reg        <= '0;
            wide_reg        <= '0;
            s_reg           <= '0;
            a_reg           <= '0;
            u_reg           <= '0;
            bq_reg          <= '0;
            ch_reg          <= '0;
            p1_reg          <= '0;
            pacc_reg        <= '0;
            x_reg           <= '0;
            k_reg           <= '0;
            och_reg         <= '{default: '0};
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready && state_reg != ST_OUT) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.kind == KIND_START)
                        begin
                            log_sum_reg     <= '0;
                            count_reg       <= '0;
                            scale_ready_reg <= 1'b0;
                        end
                        else
                        begin
                            item_reg  <= q_item;
                            lacc_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_LUM;
                        end
                    end
                end
                ST_LUM:
                begin
                    lacc_reg <= lacc_reg + 49'(mul_p);
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd2) state_reg <= ST_LUMF;
                end
                ST_LUMF:
                begin
                    lum_reg  <= lum_w;
                    m_reg    <= lum_w;
                    p_reg    <= 5'd31;
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                    ch_reg   <= '0;
                    if (item_reg.kind == KIND_STAT)
                        state_reg <= (lum_w != 32'd0 && count_reg < MAX_PIX) ? ST_NORM : ST_IDLE;
                    else
                        state_reg <= scale_ready_reg ? ST_MSL : ST_MEAN;
                end
                ST_NORM:
                begin
                    if (m_reg[31])
                        state_reg <= ST_SQ;
                    else
                    begin
                        m_reg <= {m_reg[30:0], 1'b0};
                        p_reg <= p_reg - 5'd1;
                    end
                end
                ST_SQ:
                begin
                    frac_reg <= {frac_reg[14:0], mul_p[63]};
                    m_reg    <= mul_p[63] ? mul_p[63:32] : mul_p[62:31];
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) state_reg <= ST_ACCUM;
                end
                ST_ACCUM:
                begin
                    log_sum_reg <= log_sum_reg + 48'($signed(log_val));
                    count_reg   <= count_reg + 25'd1;
                    state_reg   <= ST_IDLE;
                end
                ST_MEAN:
                begin
                    acc_reg <= 32'h4000_0000;
                    cnt_reg <= '0;
                    if (count_reg == 25'd0)
                    begin
                        t_reg     <= EPS_T;
                        state_reg <= ST_POW;
                    end
                    else
                        state_reg <= ST_MEANW;
                end
                ST_MEANW:
                begin
                    if (div_rsp.done)
                    begin
                        t_reg <= neg ? 50'(div_rsp.quo + 64'(div_rsp.rem != 49'd0))
                                     : 50'(-div_rsp.quo);
                        state_reg <= ST_POW;
                    end
                end
                ST_POW:
                begin
                    if (t_reg[4'd15 - cnt_reg]) acc_reg <= mul_p[61:30];
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15) state_reg <= ST_KEYM;
                end
                ST_KEYM:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_SCL;
                end
                ST_SCL:
                begin
                    scale_reg       <= scale_w;
                    scale_ready_reg <= 1'b1;
                    state_reg       <= ST_MSL;
                end
                ST_MSL:
                begin
                    wide_reg  <= 80'(mul_p);
                    state_reg <= ST_MSH;
                end
                ST_MSH:
                begin
                    wide_reg  <= wide_reg + {mul_p[55:0], 24'd0};
                    state_reg <= ST_SSAT;
                end
                ST_SSAT:
                begin
                    s_reg     <= (s64 > 64'(SAT48)) ? SAT48 : s64[47:0];
                    state_reg <= ST_DIVA;
                end
                ST_DIVA: state_reg <= ST_DIVAW;
                ST_DIVAW:
                begin
                    if (div_rsp.done)
                    begin
                        a_reg <= 25'h100_0000 - 25'(div_rsp.quo)
                                 - 25'(div_rsp.rem != 49'd0);
                        state_reg <= ST_DIVU;
                    end
                end
                ST_DIVU: state_reg <= ST_DIVUW;
                ST_DIVUW:
                begin
                    if (div_rsp.done)
                    begin
                        if (div_rsp.quo[63:48] != 16'd0)
                        begin
                            bq_reg    <= SAT48;
                            state_reg <= ST_CA;
                        end
                        else
                        begin
                            u_reg     <= div_rsp.quo[47:0];
                            state_reg <= ST_DIVV;
                        end
                    end
                end
                ST_DIVV: state_reg <= ST_DIVVW;
                ST_DIVVW:
                begin
                    if (div_rsp.done)
                    begin
                        bq_reg <= (div_rsp.quo >= 64'(SAT48 - 48'd65536)) ? SAT48
                                  : 48'(div_rsp.quo + 64'd65536);
                        state_reg <= ST_CA;
                    end
                end
                ST_CA:
                begin
                    p1_reg    <= mul_p[56:0];
                    cnt_reg   <= '0;
                    state_reg <= ST_PP;
                end
                ST_PP:
                begin
                    pacc_reg <= (cnt_reg == 4'd0) ? pp_add : pacc_reg + pp_add;
                    cnt_reg  <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd3) state_reg <= ST_XS;
                end
                ST_XS:
                begin
                    x_reg     <= (113'(pacc_reg) << 8) - 113'(pacc_reg);
                    k_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_KS;
                end
                ST_KS:
                begin
                    k_reg   <= k_new;
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd7)
                    begin
                        och_reg[ch_reg] <= k_new;
                        if (ch_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            ch_reg    <= ch_reg + 2'd1;
                            state_reg <= ST_CA;
                        end
                    end
                end
                ST_OUT:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {och_reg[2], och_reg[1], och_reg[0]};
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_PIX)
        else $error("pixel count passed the frame limit");

    a_sq_normalized: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQ) |-> m_reg[31])
        else $error("log2 mantissa lost normalization");

    a_scale_set: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCL) |=> scale_ready_reg)
        else $error("scale formed but not marked ready");

    a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_KS) |-> (a_reg <= 25'h100_0000))
        else $error("compression ratio above one");

endmodule

// ----- rtl/global_log_average_tone_map.sv -----
// Top level of the global log-average tone mapper: configuration registers,
// front queue, shared divider and execution unit. Depends on glatm_pkg.
//
// Flow: items are worked one at a time after a two-entry input queue. A
// statistics pixel runs the luminance, then a normalize walk of up to 32 steps,
// 16 squaring steps and the add; a map pixel runs two or three divisions, then
// per channel a product, partial products, a scaling step and a bit search;
// the first map pixel of a frame also runs the optional mean division and the
// 16-step power. The single shared multiplier and the bit-serial divider set
// the pace. Results wait in an output register while the next request runs.
module global_log_average_tone_map import glatm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // in_blue, in_green, in_red
    input  logic [1:0]  s_tuser,    // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // out_blue, out_green, out_red
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     q_valid;
    item_t    q_item;
    logic     q_pop;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key   <= KEY_RESET;
            cfg_reg.white <= WHITE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY:   cfg_reg.key   <= cfg_data;
                CFG_WHITE: cfg_reg.white <= cfg_data;
                default:   ;
            endcase
        end
    end

    glatm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    glatm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    glatm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .cfg      (cfg_reg),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
